/* sv/lfp_pkg.sv */
package lfp_pkg;

  localparam int SENSOR_COUNT = 8;
  localparam int GAIN_W = 16;
  localparam int PWM_W = 8;
  localparam int CNT_W = 10;        // phase_count
  localparam int ERR_W = 11;        // Q8 line error, +/-896
  localparam int SUM_W = 24;        // saturating integral
  localparam int SUMW_W = 13;       // weighted sensor sum, +/-2048
  localparam int NCNT_W = 4;        // black sensor count, 0..8
  localparam int DIV_W = 12;        // |weighted sum| <= 2048
  localparam int REM_W = 4;
  localparam int DER_W = 12;        // err - previous_error
  localparam int PROD_W = GAIN_W + 1 + SUM_W;
  localparam int ACC_W = PROD_W + 1;
  localparam int Q_FRAC = 16;       // Q8 error times Q8.8 gain
  localparam int STEP_W = 4;
  localparam int LOOP_W = 4;
  localparam int DIV_STEPS = DIV_W;

  // sensor weights i - 3.5 in Q8
  localparam int W_Q8_STEP = 256;
  localparam int W_Q8_OFFSET = 896;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  localparam logic [GAIN_W-1:0] GAIN_P_RST = 16'd10240;
  localparam logic [GAIN_W-1:0] GAIN_I_RST = 16'd0;
  localparam logic [GAIN_W-1:0] GAIN_D_RST = 16'd1024;
  localparam logic [PWM_W-1:0] BASE_SPEED_RST = 8'd50;
  localparam logic [PWM_W-1:0] MAX_PWM_RST = 8'd100;
  localparam logic [PWM_W-1:0] TURN_PWM_RST = 8'd140;
  localparam logic [CNT_W-1:0] PIVOT_LIMIT_RST = 10'd150;
  localparam logic [PWM_W-1:0] BRAKE_LEN_RST = 8'd6;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  typedef enum logic [2:0] {
    REG_GAIN_P      = 3'd0,
    REG_GAIN_I      = 3'd1,
    REG_GAIN_D      = 3'd2,
    REG_BASE_SPEED  = 3'd3,
    REG_MAX_PWM     = 3'd4,
    REG_TURN_PWM    = 3'd5,
    REG_PIVOT_LIMIT = 3'd6,
    REG_BRAKE_LEN   = 3'd7
  } reg_idx_t;

  typedef enum logic [3:0] {
    PH_TRACK     = 4'b0001,
    PH_BRAKE_IN  = 4'b0010,
    PH_PIVOT     = 4'b0100,
    PH_BRAKE_OUT = 4'b1000
  } phase_t;

  typedef enum logic [2:0] {
    MODE_TRACK   = 3'd0,
    MODE_SEARCH  = 3'd1,
    MODE_BRAKE   = 3'd2,
    MODE_PIVOT_L = 3'd3,
    MODE_PIVOT_R = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_DECIDE = 3'd1,
    OP_DIV    = 3'd2,
    OP_ERR    = 3'd3,
    OP_LEFT   = 3'd4,
    OP_RIGHT  = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    MUL_NONE = 2'd0,
    MUL_P    = 2'd1,
    MUL_I    = 2'd2,
    MUL_D    = 2'd3
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD = 2'd0,
    ACC_LOAD = 2'd1,
    ACC_ADD  = 2'd2
  } acc_op_t;

  typedef enum logic [1:0] {
    COND_NEXT   = 2'd0,
    COND_ALWAYS = 2'd1,
    COND_NO_PID = 2'd2,
    COND_LOOP   = 2'd3
  } cond_t;

  typedef struct packed {
    op_t              op;
    mul_sel_t         mul;
    acc_op_t          acc;
    cond_t            cond;
    logic [STEP_W-1:0] target;
    logic             last;
  } ucode_t;

  typedef struct packed {
    op_t      op;
    mul_sel_t mul;
    acc_op_t  acc;
    logic     load;
    logic     emit;
  } dp_ctrl_t;

  typedef struct packed {
    logic pid;
  } dp_flags_t;

  typedef struct packed {
    logic [GAIN_W-1:0] gain_p;
    logic [GAIN_W-1:0] gain_i;
    logic [GAIN_W-1:0] gain_d;
    logic [PWM_W-1:0]  base_speed;
    logic [PWM_W-1:0]  max_pwm;
    logic [PWM_W-1:0]  turn_pwm;
    logic [CNT_W-1:0]  pivot_limit;
    logic [PWM_W-1:0]  brake_len;
  } cfg_t;

  localparam logic [STEP_W-1:0] STEP_DECIDE = 4'd0;
  localparam logic [STEP_W-1:0] STEP_DIV    = 4'd1;
  localparam logic [STEP_W-1:0] STEP_ERR    = 4'd2;
  localparam logic [STEP_W-1:0] STEP_MUL_P  = 4'd3;
  localparam logic [STEP_W-1:0] STEP_MUL_I  = 4'd4;
  localparam logic [STEP_W-1:0] STEP_MUL_D  = 4'd5;
  localparam logic [STEP_W-1:0] STEP_ACC    = 4'd6;
  localparam logic [STEP_W-1:0] STEP_LEFT   = 4'd7;
  localparam logic [STEP_W-1:0] STEP_RIGHT  = 4'd8;
  localparam logic [STEP_W-1:0] STEP_END    = 4'd9;

  function automatic logic signed [SUMW_W-1:0] weight(input int idx);
    weight = SUMW_W'(idx * W_Q8_STEP - W_Q8_OFFSET);
  endfunction

  // control store
  function automatic ucode_t ucode(input logic [STEP_W-1:0] step);
    ucode_t w;
    case (step)
      STEP_DECIDE: w = '{OP_DECIDE, MUL_NONE, ACC_HOLD, COND_NO_PID, STEP_END, 1'b0};
      STEP_DIV:    w = '{OP_DIV, MUL_NONE, ACC_HOLD, COND_LOOP, STEP_DIV, 1'b0};
      STEP_ERR:    w = '{OP_ERR, MUL_NONE, ACC_HOLD, COND_NEXT, STEP_END, 1'b0};
      STEP_MUL_P:  w = '{OP_NONE, MUL_P, ACC_HOLD, COND_NEXT, STEP_END, 1'b0};
      STEP_MUL_I:  w = '{OP_NONE, MUL_I, ACC_LOAD, COND_NEXT, STEP_END, 1'b0};
      STEP_MUL_D:  w = '{OP_NONE, MUL_D, ACC_ADD, COND_NEXT, STEP_END, 1'b0};
      STEP_ACC:    w = '{OP_NONE, MUL_NONE, ACC_ADD, COND_NEXT, STEP_END, 1'b0};
      STEP_LEFT:   w = '{OP_LEFT, MUL_NONE, ACC_HOLD, COND_NEXT, STEP_END, 1'b0};
      STEP_RIGHT:  w = '{OP_RIGHT, MUL_NONE, ACC_HOLD, COND_NEXT, STEP_END, 1'b0};
      default:     w = '{OP_NONE, MUL_NONE, ACC_HOLD, COND_NEXT, STEP_END, 1'b1};
    endcase
    return w;
  endfunction

endpackage

/* sv/lfp_regs.sv */
module lfp_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lfp_pkg::ADDR_W-1:0]    paddr,
  input  logic [lfp_pkg::DATA_W-1:0]    pwdata,
  output logic [lfp_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  output lfp_pkg::cfg_t                 cfg
);

  lfp_pkg::reg_idx_t idx;
  logic              wr;

  assign pready = 1'b1;
  assign idx = lfp_pkg::reg_idx_t'(paddr[lfp_pkg::ADDR_W-1:2]);
  assign wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_p      <= lfp_pkg::GAIN_P_RST;
      cfg.gain_i      <= lfp_pkg::GAIN_I_RST;
      cfg.gain_d      <= lfp_pkg::GAIN_D_RST;
      cfg.base_speed  <= lfp_pkg::BASE_SPEED_RST;
      cfg.max_pwm     <= lfp_pkg::MAX_PWM_RST;
      cfg.turn_pwm    <= lfp_pkg::TURN_PWM_RST;
      cfg.pivot_limit <= lfp_pkg::PIVOT_LIMIT_RST;
      cfg.brake_len   <= lfp_pkg::BRAKE_LEN_RST;
    end else if (wr) begin
      unique case (idx)
        lfp_pkg::REG_GAIN_P:      cfg.gain_p      <= pwdata[lfp_pkg::GAIN_W-1:0];
        lfp_pkg::REG_GAIN_I:      cfg.gain_i      <= pwdata[lfp_pkg::GAIN_W-1:0];
        lfp_pkg::REG_GAIN_D:      cfg.gain_d      <= pwdata[lfp_pkg::GAIN_W-1:0];
        lfp_pkg::REG_BASE_SPEED:  cfg.base_speed  <= pwdata[lfp_pkg::PWM_W-1:0];
        lfp_pkg::REG_MAX_PWM:     cfg.max_pwm     <= pwdata[lfp_pkg::PWM_W-1:0];
        lfp_pkg::REG_TURN_PWM:    cfg.turn_pwm    <= pwdata[lfp_pkg::PWM_W-1:0];
        lfp_pkg::REG_PIVOT_LIMIT: cfg.pivot_limit <= pwdata[lfp_pkg::CNT_W-1:0];
        lfp_pkg::REG_BRAKE_LEN:   cfg.brake_len   <= pwdata[lfp_pkg::PWM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      lfp_pkg::REG_GAIN_P:      prdata[lfp_pkg::GAIN_W-1:0] = cfg.gain_p;
      lfp_pkg::REG_GAIN_I:      prdata[lfp_pkg::GAIN_W-1:0] = cfg.gain_i;
      lfp_pkg::REG_GAIN_D:      prdata[lfp_pkg::GAIN_W-1:0] = cfg.gain_d;
      lfp_pkg::REG_BASE_SPEED:  prdata[lfp_pkg::PWM_W-1:0] = cfg.base_speed;
      lfp_pkg::REG_MAX_PWM:     prdata[lfp_pkg::PWM_W-1:0] = cfg.max_pwm;
      lfp_pkg::REG_TURN_PWM:    prdata[lfp_pkg::PWM_W-1:0] = cfg.turn_pwm;
      lfp_pkg::REG_PIVOT_LIMIT: prdata[lfp_pkg::CNT_W-1:0] = cfg.pivot_limit;
      lfp_pkg::REG_BRAKE_LEN:   prdata[lfp_pkg::PWM_W-1:0] = cfg.brake_len;
      default: ;
    endcase
  end

endmodule

/* sv/lfp_seq.sv */
module lfp_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  lfp_pkg::dp_flags_t  flags,
  output lfp_pkg::dp_ctrl_t   ctrl
);

  typedef enum logic [1:0] {
    SQ_IDLE = 2'b01,
    SQ_RUN  = 2'b10
  } seq_state_t;

  seq_state_t                     state;
  logic [lfp_pkg::STEP_W-1:0]     step;
  logic [lfp_pkg::LOOP_W-1:0]     loop;
  lfp_pkg::ucode_t                uw;
  logic                           run;
  logic                           emit;
  logic                           take;

  assign run = (state == SQ_RUN);
  assign uw = lfp_pkg::ucode(step);
  assign in_stall = !(state == SQ_IDLE);
  // last step waits while the output register is still held
  assign emit = run && uw.last && (!out_valid || !out_stall);

  always_comb begin
    unique case (uw.cond)
      lfp_pkg::COND_ALWAYS: take = 1'b1;
      lfp_pkg::COND_NO_PID: take = !flags.pid;
      lfp_pkg::COND_LOOP:   take = (loop != '0);
      default:              take = 1'b0;
    endcase
  end

  always_comb begin
    ctrl.op   = run ? uw.op : lfp_pkg::OP_NONE;
    ctrl.mul  = run ? uw.mul : lfp_pkg::MUL_NONE;
    ctrl.acc  = run ? uw.acc : lfp_pkg::ACC_HOLD;
    ctrl.load = in_valid && (state == SQ_IDLE);
    ctrl.emit = emit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= SQ_IDLE;
      step      <= lfp_pkg::STEP_DECIDE;
      loop      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        SQ_IDLE: begin
          if (in_valid) begin
            state <= SQ_RUN;
            step  <= lfp_pkg::STEP_DECIDE;
          end
        end
        SQ_RUN: begin
          if (uw.last) begin
            if (emit) begin
              out_valid <= 1'b1;
              state     <= SQ_IDLE;
            end
          end else begin
            if (uw.op == lfp_pkg::OP_DECIDE) begin
              loop <= lfp_pkg::LOOP_W'(lfp_pkg::DIV_STEPS - 1);
            end else if (uw.cond == lfp_pkg::COND_LOOP && loop != '0) begin
              loop <= loop - lfp_pkg::LOOP_W'(1);
            end
            step <= take ? uw.target : step + lfp_pkg::STEP_W'(1);
          end
        end
        default: state <= SQ_IDLE;
      endcase
    end
  end

endmodule

/* sv/lfp_dp.sv */
module lfp_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  lfp_pkg::cfg_t               cfg,
  input  lfp_pkg::dp_ctrl_t           ctrl,
  input  logic [lfp_pkg::SENSOR_COUNT-1:0] sensor_bits,
  output lfp_pkg::dp_flags_t          flags,
  output logic [lfp_pkg::PWM_W-1:0]   left_pwm,
  output logic [lfp_pkg::PWM_W-1:0]   right_pwm,
  output logic                        left_reverse,
  output logic                        right_reverse,
  output logic [2:0]                  drive_mode
);

  localparam int CX_W = lfp_pkg::CNT_W + 1;

  // model state
  lfp_pkg::phase_t                       phase;
  logic                                  turn_left;
  logic [lfp_pkg::CNT_W-1:0]             phase_count;
  logic signed [lfp_pkg::ERR_W-1:0]      prev_err;
  logic signed [lfp_pkg::SUM_W-1:0]      err_sum;

  // working registers
  logic [lfp_pkg::SENSOR_COUNT-1:0]      bits_q;
  logic [lfp_pkg::REM_W-1:0]             div_rem;
  logic [lfp_pkg::DIV_W-1:0]             div_q;
  logic [lfp_pkg::NCNT_W-1:0]            div_n;
  logic                                  div_neg;
  logic signed [lfp_pkg::ERR_W-1:0]      err;
  logic signed [lfp_pkg::DER_W-1:0]      deriv;
  logic signed [lfp_pkg::PROD_W-1:0]     prod;
  logic signed [lfp_pkg::ACC_W-1:0]      acc;
  logic [lfp_pkg::PWM_W-1:0]             res_left;
  logic [lfp_pkg::PWM_W-1:0]             res_right;
  logic                                  res_lrev;
  logic                                  res_rrev;
  lfp_pkg::mode_t                        res_mode;
  logic [lfp_pkg::PWM_W-1:0]             out_left;
  logic [lfp_pkg::PWM_W-1:0]             out_right;
  logic                                  out_lrev;
  logic                                  out_rrev;
  lfp_pkg::mode_t                        out_mode;

  // decision step
  lfp_pkg::phase_t                       phase_next;
  logic                                  turn_left_next;
  logic [lfp_pkg::CNT_W-1:0]             phase_count_next;
  logic [lfp_pkg::PWM_W-1:0]             dec_left;
  logic [lfp_pkg::PWM_W-1:0]             dec_right;
  logic                                  dec_lrev;
  logic                                  dec_rrev;
  lfp_pkg::mode_t                        dec_mode;
  logic                                  dec_pid;
  logic                                  centre;
  logic [1:0]                            lc;
  logic [1:0]                            rc;
  logic                                  strong_l;
  logic                                  strong_r;
  logic [lfp_pkg::PWM_W-1:0]             len_eff;
  logic [CX_W-1:0]                       len_ext;
  logic [CX_W-1:0]                       lim_ext;
  logic [CX_W-1:0]                       cnt_inc;
  logic                                  brake_one;

  // weighted sum and divider
  logic signed [lfp_pkg::SUMW_W-1:0]     sw;
  logic [lfp_pkg::SUMW_W-1:0]            sw_abs;
  logic [lfp_pkg::NCNT_W-1:0]            n_black;
  logic [lfp_pkg::REM_W:0]               div_try;
  logic                                  div_bit;
  logic [lfp_pkg::REM_W-1:0]             div_rem_next;

  // error update
  logic signed [lfp_pkg::ERR_W-1:0]      err_next;
  logic signed [lfp_pkg::SUM_W:0]        sum_wide;
  logic signed [lfp_pkg::SUM_W-1:0]      err_sum_next;
  logic signed [lfp_pkg::DER_W-1:0]      deriv_next;

  // multiplier and wheel clamp
  logic signed [lfp_pkg::GAIN_W:0]       mul_a;
  logic signed [lfp_pkg::SUM_W-1:0]      mul_b;
  logic signed [lfp_pkg::PROD_W-1:0]     mul_p;
  logic signed [lfp_pkg::ACC_W-1:0]      prod_ext;
  logic signed [lfp_pkg::ACC_W-1:0]      acc_sh;
  logic signed [lfp_pkg::ACC_W-1:0]      wheel_sum;
  logic [lfp_pkg::PWM_W-1:0]             wheel_pwm;

  assign flags.pid = dec_pid;

  always_comb begin
    centre   = |bits_q[4:3];
    lc       = 2'(bits_q[0]) + 2'(bits_q[1]) + 2'(bits_q[2]);
    rc       = 2'(bits_q[5]) + 2'(bits_q[6]) + 2'(bits_q[7]);
    strong_l = (lc >= 2'd2) && (rc <= 2'd1);
    strong_r = (rc >= 2'd2) && (lc <= 2'd1);
    len_eff  = (cfg.brake_len == '0) ? lfp_pkg::PWM_W'(1) : cfg.brake_len;
    len_ext  = CX_W'(len_eff);
    lim_ext  = (cfg.pivot_limit == '0) ? CX_W'(1) : CX_W'(cfg.pivot_limit);
    cnt_inc  = CX_W'(phase_count) + CX_W'(1);
    brake_one = (len_eff == lfp_pkg::PWM_W'(1));

    phase_next       = phase;
    turn_left_next   = turn_left;
    phase_count_next = phase_count;
    dec_left  = '0;
    dec_right = '0;
    dec_lrev  = 1'b0;
    dec_rrev  = 1'b0;
    dec_mode  = lfp_pkg::MODE_BRAKE;
    dec_pid   = 1'b0;

    unique case (phase)
      lfp_pkg::PH_BRAKE_IN: begin
        if (cnt_inc >= len_ext) begin
          phase_next       = lfp_pkg::PH_PIVOT;
          phase_count_next = '0;
        end else begin
          phase_count_next = cnt_inc[lfp_pkg::CNT_W-1:0];
        end
      end
      lfp_pkg::PH_BRAKE_OUT: begin
        if (cnt_inc >= len_ext) begin
          phase_next       = lfp_pkg::PH_TRACK;
          phase_count_next = '0;
        end else begin
          phase_count_next = cnt_inc[lfp_pkg::CNT_W-1:0];
        end
      end
      lfp_pkg::PH_PIVOT: begin
        if (centre) begin
          // line found: this sample opens the closing brake
          phase_next       = brake_one ? lfp_pkg::PH_TRACK : lfp_pkg::PH_BRAKE_OUT;
          phase_count_next = brake_one ? '0 : lfp_pkg::CNT_W'(1);
        end else begin
          dec_left  = cfg.turn_pwm;
          dec_right = cfg.turn_pwm;
          dec_lrev  = turn_left;
          dec_rrev  = !turn_left;
          dec_mode  = turn_left ? lfp_pkg::MODE_PIVOT_L : lfp_pkg::MODE_PIVOT_R;
          if (cnt_inc >= lim_ext) begin
            phase_next       = lfp_pkg::PH_BRAKE_OUT;
            phase_count_next = '0;
          end else begin
            phase_count_next = cnt_inc[lfp_pkg::CNT_W-1:0];
          end
        end
      end
      default: begin
        phase_next = lfp_pkg::PH_TRACK;
        if ((strong_l || strong_r) && !centre) begin
          turn_left_next   = strong_l;
          phase_next       = brake_one ? lfp_pkg::PH_PIVOT : lfp_pkg::PH_BRAKE_IN;
          phase_count_next = brake_one ? '0 : lfp_pkg::CNT_W'(1);
        end else if (bits_q == '0) begin
          dec_left  = cfg.base_speed;
          dec_right = cfg.base_speed;
          dec_lrev  = prev_err[lfp_pkg::ERR_W-1];
          dec_rrev  = !prev_err[lfp_pkg::ERR_W-1];
          dec_mode  = lfp_pkg::MODE_SEARCH;
        end else begin
          dec_mode = lfp_pkg::MODE_TRACK;
          dec_pid  = 1'b1;
        end
      end
    endcase
  end

  always_comb begin
    sw      = '0;
    n_black = '0;
    for (int i = 0; i < lfp_pkg::SENSOR_COUNT; i++) begin
      if (bits_q[i]) begin
        sw      = sw + lfp_pkg::weight(i);
        n_black = n_black + lfp_pkg::NCNT_W'(1);
      end
    end
    sw_abs = sw[lfp_pkg::SUMW_W-1] ? -sw : sw;
  end

  // one restoring step: remainder stays below the divisor
  always_comb begin
    div_try = {div_rem, div_q[lfp_pkg::DIV_W-1]};
    div_bit = (div_try >= {1'b0, div_n});
    div_rem_next = div_bit ? lfp_pkg::REM_W'(div_try - {1'b0, div_n})
                           : div_try[lfp_pkg::REM_W-1:0];
  end

  always_comb begin
    err_next = div_neg ? -$signed(div_q[lfp_pkg::ERR_W-1:0])
                       : $signed(div_q[lfp_pkg::ERR_W-1:0]);
    sum_wide = {err_sum[lfp_pkg::SUM_W-1], err_sum}
             + {{(lfp_pkg::SUM_W+1-lfp_pkg::ERR_W){err_next[lfp_pkg::ERR_W-1]}}, err_next};
    if (sum_wide[lfp_pkg::SUM_W] != sum_wide[lfp_pkg::SUM_W-1]) begin
      err_sum_next = sum_wide[lfp_pkg::SUM_W] ? lfp_pkg::SUM_MIN : lfp_pkg::SUM_MAX;
    end else begin
      err_sum_next = sum_wide[lfp_pkg::SUM_W-1:0];
    end
    deriv_next = {err_next[lfp_pkg::ERR_W-1], err_next}
               - {prev_err[lfp_pkg::ERR_W-1], prev_err};
  end

  always_comb begin
    case (ctrl.mul)
      lfp_pkg::MUL_P: begin
        mul_a = {1'b0, cfg.gain_p};
        mul_b = {{(lfp_pkg::SUM_W-lfp_pkg::ERR_W){err[lfp_pkg::ERR_W-1]}}, err};
      end
      lfp_pkg::MUL_I: begin
        mul_a = {1'b0, cfg.gain_i};
        mul_b = err_sum;
      end
      default: begin
        mul_a = {1'b0, cfg.gain_d};
        mul_b = {{(lfp_pkg::SUM_W-lfp_pkg::DER_W){deriv[lfp_pkg::DER_W-1]}}, deriv};
      end
    endcase
    mul_p = mul_a * mul_b;
    prod_ext = {{(lfp_pkg::ACC_W-lfp_pkg::PROD_W){prod[lfp_pkg::PROD_W-1]}}, prod};
  end

  // base + floor(acc / 2^16), clamped to 0..max_pwm
  always_comb begin
    acc_sh    = acc >>> lfp_pkg::Q_FRAC;
    wheel_sum = acc_sh + $signed({{(lfp_pkg::ACC_W-lfp_pkg::PWM_W){1'b0}}, cfg.base_speed});
    if (wheel_sum[lfp_pkg::ACC_W-1]) begin
      wheel_pwm = '0;
    end else if (wheel_sum[lfp_pkg::ACC_W-2:0]
                 > {{(lfp_pkg::ACC_W-1-lfp_pkg::PWM_W){1'b0}}, cfg.max_pwm}) begin
      wheel_pwm = cfg.max_pwm;
    end else begin
      wheel_pwm = wheel_sum[lfp_pkg::PWM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= lfp_pkg::PH_TRACK;
      turn_left   <= 1'b0;
      phase_count <= '0;
      prev_err    <= '0;
      err_sum     <= '0;
    end else begin
      if (ctrl.op == lfp_pkg::OP_DECIDE) begin
        phase       <= phase_next;
        turn_left   <= turn_left_next;
        phase_count <= phase_count_next;
      end
      if (ctrl.op == lfp_pkg::OP_ERR) begin
        prev_err <= err_next;
        err_sum  <= err_sum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      bits_q <= sensor_bits;
    end
    case (ctrl.op)
      lfp_pkg::OP_DECIDE: begin
        div_rem  <= '0;
        div_q    <= sw_abs[lfp_pkg::DIV_W-1:0];
        div_n    <= n_black;
        div_neg  <= sw[lfp_pkg::SUMW_W-1];
        res_left  <= dec_left;
        res_right <= dec_right;
        res_lrev  <= dec_lrev;
        res_rrev  <= dec_rrev;
        res_mode  <= dec_mode;
      end
      lfp_pkg::OP_DIV: begin
        div_rem <= div_rem_next;
        div_q   <= {div_q[lfp_pkg::DIV_W-2:0], div_bit};
      end
      lfp_pkg::OP_ERR: begin
        err   <= err_next;
        deriv <= deriv_next;
      end
      lfp_pkg::OP_LEFT: begin
        res_left <= wheel_pwm;
        acc      <= -acc;
      end
      lfp_pkg::OP_RIGHT: begin
        res_right <= wheel_pwm;
      end
      default: ;
    endcase
    if (ctrl.mul != lfp_pkg::MUL_NONE) begin
      prod <= mul_p;
    end
    case (ctrl.acc)
      lfp_pkg::ACC_LOAD: acc <= prod_ext;
      lfp_pkg::ACC_ADD:  acc <= acc + prod_ext;
      default: ;
    endcase
    if (ctrl.emit) begin
      out_left  <= res_left;
      out_right <= res_right;
      out_lrev  <= res_lrev;
      out_rrev  <= res_rrev;
      out_mode  <= res_mode;
    end
  end

  assign left_pwm      = out_left;
  assign right_pwm     = out_right;
  assign left_reverse  = out_lrev;
  assign right_reverse = out_rrev;
  assign drive_mode    = out_mode;

endmodule

/* sv/line_follower_pid_with_corner_pivot.sv */
// Line follower controller: weighted-sensor PID tracking, corner pivot, lost-line search.
// Input channel: in_valid / in_stall with sensor_bits (bit 0 = far-left sensor).
//   An item is taken at an edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with left_pwm, right_pwm, left_reverse,
//   right_reverse and drive_mode (0 track, 1 search, 2 brake, 3/4 pivot left/right).
// Config: APB-style, registers at byte addresses 0x00..0x1C (gains, speeds, limits).
//   Writes belong to idle periods; pready is tied high, reads return register values.
// Sequencing: brake, pivot and search samples go from the decision step to the output
//   step. Tracking samples with a line also run the 12-step radix-2 divider that forms
//   the mean weight, then the error update, three passes through one shared 17x24
//   multiplier, an accumulate step, and the left and right wheel steps.
// in_stall stays high from acceptance until the result is moved to the output register.
// Reset (rst, synchronous) returns to tracking with cleared PID state and default
// registers; out_valid drops and the sequencer idles.
// If out_stall holds a result, the next item still runs and waits on its last step.
module line_follower_pid_with_corner_pivot (
  input  logic                               clk,
  input  logic                               rst,
  // sample in
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [lfp_pkg::SENSOR_COUNT-1:0]   sensor_bits,
  // drive command out
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [lfp_pkg::PWM_W-1:0]          left_pwm,
  output logic [lfp_pkg::PWM_W-1:0]          right_pwm,
  output logic                               left_reverse,
  output logic                               right_reverse,
  output logic [2:0]                         drive_mode,
  // register port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [lfp_pkg::ADDR_W-1:0]         paddr,
  input  logic [lfp_pkg::DATA_W-1:0]         pwdata,
  output logic [lfp_pkg::DATA_W-1:0]         prdata,
  output logic                               pready
);

  lfp_pkg::cfg_t      cfg;
  lfp_pkg::dp_ctrl_t  ctrl;
  lfp_pkg::dp_flags_t flags;

  lfp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // step counter + control store; owns both handshakes
  lfp_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .flags     (flags),
    .ctrl      (ctrl)
  );

  // mode logic, divider, multiplier, accumulator, result/output registers
  lfp_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .ctrl          (ctrl),
    .sensor_bits   (sensor_bits),
    .flags         (flags),
    .left_pwm      (left_pwm),
    .right_pwm     (right_pwm),
    .left_reverse  (left_reverse),
    .right_reverse (right_reverse),
    .drive_mode    (drive_mode)
  );

endmodule

/* sv/lfp_checker.sv */
module lfp_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [lfp_pkg::PWM_W-1:0]     left_pwm,
  input logic [lfp_pkg::PWM_W-1:0]     right_pwm,
  input logic                          left_reverse,
  input logic                          right_reverse,
  input logic [2:0]                    drive_mode
);

  // one item at a time: after taking an item the input is stalled
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after accept");

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(left_pwm) && $stable(right_pwm)
                                  && $stable(drive_mode)))
    else $error("stalled result changed");

  a_brake_is_stop: assert property (@(posedge clk) disable iff (rst)
    (out_valid && drive_mode == lfp_pkg::MODE_BRAKE) |->
      (left_pwm == '0 && right_pwm == '0 && !left_reverse && !right_reverse))
    else $error("brake with wheels running");

  a_track_forward: assert property (@(posedge clk) disable iff (rst)
    (out_valid && drive_mode == lfp_pkg::MODE_TRACK) |-> (!left_reverse && !right_reverse))
    else $error("tracking with a wheel reversed");

  a_pivot_opposed: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (drive_mode == lfp_pkg::MODE_SEARCH || drive_mode == lfp_pkg::MODE_PIVOT_L
                   || drive_mode == lfp_pkg::MODE_PIVOT_R)) |->
      (left_pwm == right_pwm && (left_reverse != right_reverse)))
    else $error("pivot wheels not opposed");

endmodule

bind line_follower_pid_with_corner_pivot lfp_checker u_lfp_checker (.*);

/* tb/sv/line_follower_pid_with_corner_pivot_tb.sv */
module line_follower_pid_with_corner_pivot_tb;
  import lfp_pkg::*;

  // Watchdog. Most of the slowest legal run is the integral soak of tracking samples.
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int HOLD_CYCLES = 300;     // long receiver hold-off used to back the block up
  localparam int SETTLE_CYCLES = 40;    // idle time after the last result
  localparam int SOAK_LEN = 9400;       // far-left samples: 9363 of them pin the integral low

  // Hand-picked opening sequence run at the reset register values. Brake length is 6.
  // In order: search right, centered, far left, search left, far right, search right,
  // all black, a wide center blob, then a strong left corner. The five samples after
  // the corner are ignored by the brake. Next come two left pivots, and a center hit that
  // ends the pivot and starts the closing brake (five more ignored samples). Last is a
  // strong right corner with the far-left sensor still black, then two brake samples.
  localparam logic [SENSOR_COUNT-1:0] OPENING [0:24] = '{
    8'h00, 8'h18, 8'h01, 8'h00, 8'h80, 8'h00, 8'hFF, 8'h3C, 8'h07,
    8'h55, 8'hAA, 8'h18, 8'h24, 8'hFF,
    8'h00, 8'h20, 8'h08,
    8'h01, 8'h02, 8'h04, 8'h40, 8'h10,
    8'hC1, 8'hFF, 8'h00
  };

  typedef struct packed {
    logic [PWM_W-1:0] left_pwm;
    logic [PWM_W-1:0] right_pwm;
    logic             left_reverse;
    logic             right_reverse;
    mode_t            mode;
  } drive_cmd_t;

  // Own model of the controller plus the queue of drive commands still owed by the block.
  class drive_scoreboard;
    cfg_t                     cfg;
    phase_t                   phase;
    bit                       turn_left;
    logic [CNT_W-1:0]         phase_count;
    logic signed [ERR_W-1:0]  prev_err;
    logic signed [SUM_W-1:0]  err_sum;
    drive_cmd_t               pending[$];
    int errors, samples, checked, corners, timeouts, searches, clamps;

    function new();
      cfg.gain_p = GAIN_P_RST;
      cfg.gain_i = GAIN_I_RST;
      cfg.gain_d = GAIN_D_RST;
      cfg.base_speed = BASE_SPEED_RST;
      cfg.max_pwm = MAX_PWM_RST;
      cfg.turn_pwm = TURN_PWM_RST;
      cfg.pivot_limit = PIVOT_LIMIT_RST;
      cfg.brake_len = BRAKE_LEN_RST;
      phase = PH_TRACK;
      turn_left = 1'b0;
      phase_count = '0;
      prev_err = '0;
      err_sum = '0;
    endfunction

    function void write_register(reg_idx_t idx, logic [DATA_W-1:0] value);
      case (idx)
        REG_GAIN_P:      cfg.gain_p = value[GAIN_W-1:0];
        REG_GAIN_I:      cfg.gain_i = value[GAIN_W-1:0];
        REG_GAIN_D:      cfg.gain_d = value[GAIN_W-1:0];
        REG_BASE_SPEED:  cfg.base_speed = value[PWM_W-1:0];
        REG_MAX_PWM:     cfg.max_pwm = value[PWM_W-1:0];
        REG_TURN_PWM:    cfg.turn_pwm = value[PWM_W-1:0];
        REG_PIVOT_LIMIT: cfg.pivot_limit = value[CNT_W-1:0];
        REG_BRAKE_LEN:   cfg.brake_len = value[PWM_W-1:0];
        default: ;
      endcase
    endfunction

    // one full-stop sample; a zero length acts as one
    function drive_cmd_t brake_sample(phase_t after);
      int len;
      len = (cfg.brake_len != 0) ? int'(cfg.brake_len) : 1;
      phase_count++;
      if (phase_count >= len) begin
        phase = after;
        phase_count = '0;
      end
      return '{8'd0, 8'd0, 1'b0, 1'b0, MODE_BRAKE};
    endfunction

    function drive_cmd_t next_command(logic [SENSOR_COUNT-1:0] bits);
      logic   centre;
      int     lc, rc, lim, sum_w, n, err, deriv;
      longint acc, corr, lv, rv;
      centre = |bits[4:3];
      case (phase)
        PH_BRAKE_IN:  return brake_sample(PH_PIVOT);
        PH_BRAKE_OUT: return brake_sample(PH_TRACK);
        PH_PIVOT: begin
          lim = (cfg.pivot_limit != 0) ? int'(cfg.pivot_limit) : 1;
          // center seen: this sample is already the first closing brake
          if (centre) begin
            phase = PH_BRAKE_OUT;
            phase_count = '0;
            return brake_sample(PH_TRACK);
          end
          phase_count++;
          if (phase_count >= lim) begin
            phase = PH_BRAKE_OUT;
            phase_count = '0;
            timeouts++;
          end
          if (turn_left)
            return '{cfg.turn_pwm, cfg.turn_pwm, 1'b1, 1'b0, MODE_PIVOT_L};
          return '{cfg.turn_pwm, cfg.turn_pwm, 1'b0, 1'b1, MODE_PIVOT_R};
        end
        default: ;
      endcase

      // tracking
      lc = $countones(bits[2:0]);
      rc = $countones(bits[7:5]);
      if (((lc >= 2 && rc <= 1) || (rc >= 2 && lc <= 1)) && !centre) begin
        turn_left = (lc >= 2 && rc <= 1);
        phase = PH_BRAKE_IN;
        phase_count = '0;
        corners++;
        return brake_sample(PH_PIVOT);
      end
      if (bits == '0) begin
        searches++;
        if (prev_err >= 0)
          return '{cfg.base_speed, cfg.base_speed, 1'b0, 1'b1, MODE_SEARCH};
        return '{cfg.base_speed, cfg.base_speed, 1'b1, 1'b0, MODE_SEARCH};
      end

      sum_w = 0;
      n = 0;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        if (bits[i]) begin
          sum_w += i * W_Q8_STEP - W_Q8_OFFSET;
          n++;
        end
      end
      err = sum_w / n;                  // truncates toward zero
      acc = longint'(err_sum) + err;
      if (acc > longint'(SUM_MAX)) begin
        acc = longint'(SUM_MAX);
        clamps++;
      end
      if (acc < longint'(SUM_MIN)) begin
        acc = longint'(SUM_MIN);
        clamps++;
      end
      err_sum = acc[SUM_W-1:0];
      deriv = err - int'(prev_err);
      prev_err = err[ERR_W-1:0];
      corr = longint'(cfg.gain_p) * err + longint'(cfg.gain_i) * longint'(err_sum)
           + longint'(cfg.gain_d) * deriv;
      lv = longint'(cfg.base_speed) + (corr >>> Q_FRAC);     // floor of Q16 product
      rv = longint'(cfg.base_speed) + ((-corr) >>> Q_FRAC);
      if (lv < 0) lv = 0;
      if (lv > longint'(cfg.max_pwm)) lv = longint'(cfg.max_pwm);
      if (rv < 0) rv = 0;
      if (rv > longint'(cfg.max_pwm)) rv = longint'(cfg.max_pwm);
      return '{lv[PWM_W-1:0], rv[PWM_W-1:0], 1'b0, 1'b0, MODE_TRACK};
    endfunction

    function void note_sample(logic [SENSOR_COUNT-1:0] bits);
      samples++;
      pending.push_back(next_command(bits));
    endfunction

    function void check_command(drive_cmd_t got);
      drive_cmd_t want;
      if (pending.size() == 0) begin
        $error("drive command with no sample outstanding: mode %0d", got.mode);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.left_pwm !== want.left_pwm) begin
        $error("left_pwm: expected %0d, got %0d", want.left_pwm, got.left_pwm);
        errors++;
      end
      if (got.right_pwm !== want.right_pwm) begin
        $error("right_pwm: expected %0d, got %0d", want.right_pwm, got.right_pwm);
        errors++;
      end
      if (got.left_reverse !== want.left_reverse) begin
        $error("left_reverse: expected %0d, got %0d", want.left_reverse, got.left_reverse);
        errors++;
      end
      if (got.right_reverse !== want.right_reverse) begin
        $error("right_reverse: expected %0d, got %0d", want.right_reverse, got.right_reverse);
        errors++;
      end
      if (got.mode !== want.mode) begin
        $error("drive_mode: expected %0d, got %0d", want.mode, got.mode);
        errors++;
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [SENSOR_COUNT-1:0]  sensor_bits = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [PWM_W-1:0]         left_pwm;
  logic [PWM_W-1:0]         right_pwm;
  logic                     left_reverse;
  logic                     right_reverse;
  logic [2:0]               drive_mode;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [ADDR_W-1:0]        paddr = '0;
  logic [DATA_W-1:0]        pwdata = '0;
  logic [DATA_W-1:0]        prdata;
  logic                     pready;

  drive_scoreboard sb = new();

  // Idle rates in percent of cycles. Set by the main sequence only between phases.
  int  gap_pct = 0;
  int  stall_pct = 0;
  bit  hold_request = 1'b0;
  logic hold_active = 1'b0;
  int  cycles = 0;

  line_follower_pid_with_corner_pivot DUT (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d drive commands outstanding",
               cycles, sb.pending.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Both channels are sampled at the edge, before that edge's updates land. Results
  // are checked before the same edge's input is noted. That keeps the queue order
  // right whatever order the simulator runs things in.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall)
        sb.check_command('{left_pwm, right_pwm, left_reverse, right_reverse,
                           mode_t'(drive_mode)});
      if (in_valid && !in_stall)
        sb.note_sample(sensor_bits);
    end
  end

  // Receiver: random stalls at the current rate. While a hold-off runs, it stalls solidly.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= hold_active || ($urandom_range(99) < stall_pct);
    end
  end

  // The hold-off counts its own cycles. The sender keeps offering items meanwhile,
  // so the output register fills, the next sample parks on its last step, and
  // in_stall stays up.
  initial begin
    wait (hold_request);
    @(posedge clk);
    hold_active <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active <= 1'b0;
  end

  // Offer one sample. Random idle cycles come first, then hold until accepted. The
  // caller is always at a clock edge, and valid gets a single update per edge.
  task automatic send_sample(input logic [SENSOR_COUNT-1:0] bits);
    if ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    in_valid <= 1'b1;
    sensor_bits <= bits;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid, let every owed command come out, then leave room for the pipeline.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: setup cycle, access cycle, then psel and penable drop before the next access.
  task automatic write_register(input reg_idx_t idx, input logic [DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);              // register takes the value at this edge
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.write_register(idx, value);
    @(posedge clk);
  endtask

  task automatic load_settings(input cfg_t s);
    write_register(REG_GAIN_P, DATA_W'(s.gain_p));
    write_register(REG_GAIN_I, DATA_W'(s.gain_i));
    write_register(REG_GAIN_D, DATA_W'(s.gain_d));
    write_register(REG_BASE_SPEED, DATA_W'(s.base_speed));
    write_register(REG_MAX_PWM, DATA_W'(s.max_pwm));
    write_register(REG_TURN_PWM, DATA_W'(s.turn_pwm));
    write_register(REG_PIVOT_LIMIT, DATA_W'(s.pivot_limit));
    write_register(REG_BRAKE_LEN, DATA_W'(s.brake_len));
  endtask

  // Track-shaped samples. Two fifths are a 1-3 sensor line at a random spot. Two fifths
  // are corners, empty views or center hits, which drive the brake/pivot/search paths.
  // The rest is raw noise.
  function automatic logic [SENSOR_COUNT-1:0] random_sample();
    logic [SENSOR_COUNT-1:0] s;
    int width, pos;
    logic [2:0] grp;
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        width = $urandom_range(1, 3);
        pos = $urandom_range(0, SENSOR_COUNT - width);
        s = SENSOR_COUNT'(((1 << width) - 1) << pos);
      end
      4: begin                       // strong left, maybe one stray right sensor
        do grp = 3'($urandom_range(3, 7)); while ($countones(grp) < 2);
        s = {3'b000, 2'b00, grp};
        if ($urandom_range(1)) s[$urandom_range(5, 7)] = 1'b1;
      end
      5: begin                       // strong right, maybe one stray left sensor
        do grp = 3'($urandom_range(3, 7)); while ($countones(grp) < 2);
        s = {grp, 2'b00, 3'b000};
        if ($urandom_range(1)) s[$urandom_range(0, 2)] = 1'b1;
      end
      6: s = '0;
      7: begin                       // center black with random surroundings
        s = SENSOR_COUNT'($urandom_range(255)) & 8'hE7;
        s[4:3] = 2'($urandom_range(1, 3));
      end
      default: s = SENSOR_COUNT'($urandom_range(255));
    endcase
    return s;
  endfunction

  task automatic run_random(input int count);
    repeat (count) send_sample(random_sample());
  endtask

  initial begin
    cfg_t s;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Phase 0: reset register values. Sender idles lightly, receiver heavily.
    gap_pct = 12;
    stall_pct = 64;
    foreach (OPENING[i]) send_sample(OPENING[i]);
    run_random(150);
    settle();

    // Phase 1: integral on, zero brake and pivot limits (both act as one).
    s.gain_p = 16'($urandom_range(2048, 20000));
    s.gain_i = 16'd256;
    s.gain_d = 16'd2048;
    s.base_speed = 8'd120;
    s.max_pwm = 8'd200;
    s.turn_pwm = 8'd90;
    s.pivot_limit = 10'd0;
    s.brake_len = 8'd0;
    load_settings(s);
    run_random(150);
    settle();

    // Phase 2: gains and levels at zero, brake length 2, pivot limit 5. Idle rates swap: sender heavy, receiver light.
    gap_pct = 64;
    stall_pct = 12;
    s = '0;
    s.pivot_limit = 10'd5;
    s.brake_len = 8'd2;
    load_settings(s);
    run_random(100);
    settle();

    // Phase 3: gains and levels at full scale, shortest brake and pivot.
    s.gain_p = 16'hFFFF;
    s.gain_i = 16'hFFFF;
    s.gain_d = 16'hFFFF;
    s.base_speed = 8'd255;
    s.max_pwm = 8'd255;
    s.turn_pwm = 8'd255;
    s.pivot_limit = 10'd1;
    s.brake_len = 8'd1;
    load_settings(s);
    run_random(150);
    settle();

    // Phase 4: longest brake and pivot, random gains, no idling. The long receiver
    // hold-off starts here while samples keep arriving back to back.
    gap_pct = 0;
    stall_pct = 0;
    s.gain_p = 16'($urandom_range(65535));
    s.gain_i = 16'($urandom_range(512));
    s.gain_d = 16'($urandom_range(65535));
    s.base_speed = 8'($urandom_range(255));
    s.max_pwm = 8'($urandom_range(255));
    s.turn_pwm = 8'($urandom_range(255));
    s.pivot_limit = 10'd1023;
    s.brake_len = 8'd255;
    load_settings(s);
    hold_request = 1'b1;
    run_random(700);
    settle();

    // Phase 5: integral-only control. A long run of far-left samples drives the sum
    // into its negative clamp; random samples then pull it back.
    s.gain_p = 16'd0;
    s.gain_i = 16'd1;
    s.gain_d = 16'd0;
    s.base_speed = 8'd128;
    s.max_pwm = 8'd255;
    s.turn_pwm = 8'd200;
    s.pivot_limit = 10'd20;
    s.brake_len = 8'd3;
    load_settings(s);
    repeat (SOAK_LEN) send_sample(8'h01);
    run_random(60);
    settle();

    $display("Ran %0d sensor samples through six register settings; %0d drive commands checked.",
             sb.samples, sb.checked);
    $display("Saw %0d corners, %0d pivot timeouts, %0d search samples, %0d integral clamps.",
             sb.corners, sb.timeouts, sb.searches, sb.clamps);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
